// ----- hdl/aeg_pkg.sv -----
package aeg_pkg;

    // Default widths of the counter and of the internal fraction
    localparam int TICK_BITS_DEF = 17;
    localparam int FRAC_BITS_DEF = 23;

    // Fixed field widths
    localparam int CFG_W     = 17;
    localparam int LVL_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Register file
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ATTACK_TICKS  = 3'd0;
    localparam t_cfg_idx CFG_DECAY_TICKS   = 3'd1;
    localparam t_cfg_idx CFG_RELEASE_TICKS = 3'd2;
    localparam t_cfg_idx CFG_ATTACK_LEVEL  = 3'd3;
    localparam t_cfg_idx CFG_SUSTAIN_LEVEL = 3'd4;

    localparam logic [CFG_W-1:0] TICKS_RST = 17'd19200;
    localparam logic [LVL_W-1:0] LEVEL_RST = 16'd32768;

    // Envelope segment, also the phase code on the output
    typedef enum logic [2:0] {
        SEG_IDLE    = 3'd0,
        SEG_ATTACK  = 3'd1,
        SEG_DECAY   = 3'd2,
        SEG_SUSTAIN = 3'd3,
        SEG_RELEASE = 3'd4
    } t_seg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_ctrl_state;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic accept;
        logic prep;
        logic step;
        logic finish;
    } t_dp_cmd;

endpackage

// ----- hdl/aeg_ctrl.sv -----
module aeg_ctrl #(
    parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output aeg_pkg::t_dp_cmd o_cmd
);
    import aeg_pkg::*;

    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    t_ctrl_state      r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

// ----- hdl/aeg_dp.sv -----
module aeg_dp #(
    parameter int TICK_BITS = aeg_pkg::TICK_BITS_DEF,
    parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  aeg_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [aeg_pkg::CFG_W-1:0]  i_cfg_data,
    input  aeg_pkg::t_dp_cmd           i_cmd,
    input  logic                       i_gate,
    output logic [aeg_pkg::LVL_W-1:0]  o_level,
    output aeg_pkg::t_seg              o_phase
);
    import aeg_pkg::*;

    localparam int ENV_W     = FRAC_BITS + 1;
    localparam int DIF_W     = FRAC_BITS + 2;
    localparam int LVL_SHIFT = FRAC_BITS - 15;

    // Configuration registers
    logic [CFG_W-1:0] r_cfg_atk, r_cfg_dec, r_cfg_rel;
    logic [LVL_W-1:0] r_cfg_alvl, r_cfg_slvl;

    // Settings latched at note start
    logic [TICK_BITS-1:0] r_hold_atk, r_hold_dec, r_hold_rel;
    logic [LVL_W-1:0]     r_hold_alvl, r_hold_slvl;

    // Envelope state
    t_seg                 r_seg;
    logic [TICK_BITS-1:0] r_elapsed;
    logic [ENV_W-1:0]     r_env;

    // Per-tick working registers
    logic                 r_timed, r_neg;
    t_seg                 r_next;
    logic [TICK_BITS-1:0] r_len, r_dvs, r_rem;
    logic [ENV_W-1:0]     r_quo;

    // Output register
    logic [LVL_W-1:0] r_level;
    t_seg             r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_atk  <= TICKS_RST;
            r_cfg_dec  <= TICKS_RST;
            r_cfg_rel  <= TICKS_RST;
            r_cfg_alvl <= LEVEL_RST;
            r_cfg_slvl <= LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK_TICKS:  r_cfg_atk  <= i_cfg_data;
                CFG_DECAY_TICKS:   r_cfg_dec  <= i_cfg_data;
                CFG_RELEASE_TICKS: r_cfg_rel  <= i_cfg_data;
                CFG_ATTACK_LEVEL:  r_cfg_alvl <= i_cfg_data[LVL_W-1:0];
                CFG_SUSTAIN_LEVEL: r_cfg_slvl <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Gate handling on the accepted beat
    logic                 n_latch;
    t_seg                 n_seg_acc;
    logic [TICK_BITS-1:0] n_el_acc;

    always_comb begin
        n_latch   = (r_seg == SEG_IDLE) && i_gate;
        n_seg_acc = r_seg;
        n_el_acc  = r_elapsed;
        if (n_latch) begin
            n_seg_acc = SEG_ATTACK;
            n_el_acc  = '0;
        end
        if ((r_seg == SEG_ATTACK || r_seg == SEG_DECAY || r_seg == SEG_SUSTAIN) && !i_gate) begin
            n_seg_acc = SEG_RELEASE;
            n_el_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && n_latch) begin
            r_hold_atk  <= TICK_BITS'(r_cfg_atk);
            r_hold_dec  <= TICK_BITS'(r_cfg_dec);
            r_hold_rel  <= TICK_BITS'(r_cfg_rel);
            r_hold_alvl <= r_cfg_alvl;
            r_hold_slvl <= r_cfg_slvl;
        end
    end

    // Segment setup: length, target and the division operands
    logic                 n_timed;
    t_seg                 n_next;
    logic [TICK_BITS-1:0] n_len_raw, n_len, n_remain;
    logic [ENV_W-1:0]     n_target, n_mag;
    logic [DIF_W-1:0]     n_diff, n_diff_neg;

    always_comb begin
        n_timed   = 1'b1;
        n_len_raw = r_hold_atk;
        n_target  = ENV_W'(r_hold_alvl) << LVL_SHIFT;
        n_next    = SEG_DECAY;
        unique case (r_seg)
            SEG_ATTACK: begin
                n_len_raw = r_hold_atk;
                n_target  = ENV_W'(r_hold_alvl) << LVL_SHIFT;
                n_next    = SEG_DECAY;
            end
            SEG_DECAY: begin
                n_len_raw = r_hold_dec;
                n_target  = ENV_W'(r_hold_slvl) << LVL_SHIFT;
                n_next    = SEG_SUSTAIN;
            end
            SEG_RELEASE: begin
                n_len_raw = r_hold_rel;
                n_target  = '0;
                n_next    = SEG_IDLE;
            end
            default: begin
                // hold the level: zero step
                n_timed   = 1'b0;
                n_len_raw = '0;
                n_target  = r_env;
                n_next    = r_seg;
            end
        endcase
        n_len      = (n_len_raw == '0) ? TICK_BITS'(1) : n_len_raw;
        n_remain   = (r_elapsed < n_len) ? (n_len - r_elapsed) : TICK_BITS'(1);
        n_diff     = DIF_W'(n_target) - DIF_W'(r_env);
        n_diff_neg = -n_diff;
        n_mag      = n_diff[DIF_W-1] ? n_diff_neg[ENV_W-1:0] : n_diff[ENV_W-1:0];
    end

    // Restoring division, one quotient bit per step
    logic [TICK_BITS:0] n_shifted, n_trial;

    always_comb begin
        n_shifted = {r_rem, r_quo[ENV_W-1]};
        n_trial   = n_shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_timed <= n_timed;
            r_next  <= n_next;
            r_len   <= n_len;
            r_neg   <= n_diff[DIF_W-1];
            r_dvs   <= n_remain;
            r_quo   <= n_mag;
            r_rem   <= '0;
        end else if (i_cmd.step) begin
            if (!n_trial[TICK_BITS]) begin
                r_rem <= n_trial[TICK_BITS-1:0];
                r_quo <= {r_quo[ENV_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shifted[TICK_BITS-1:0];
                r_quo <= {r_quo[ENV_W-2:0], 1'b0};
            end
        end
    end

    // Step the level and advance the counter
    logic [DIF_W-1:0]     n_q, n_sum;
    logic [ENV_W-1:0]     n_env_new;
    logic [TICK_BITS-1:0] n_el_inc, n_el_fin;
    t_seg                 n_seg_fin;

    always_comb begin
        n_q       = r_neg ? -{1'b0, r_quo} : {1'b0, r_quo};
        n_sum     = {1'b0, r_env} + n_q;
        n_env_new = n_sum[ENV_W-1:0];
        n_el_inc  = r_elapsed + TICK_BITS'(1);
        n_el_fin  = r_elapsed;
        n_seg_fin = r_seg;
        if (r_timed) begin
            if (n_el_inc >= r_len || n_el_inc == '0) begin
                n_el_fin  = '0;
                n_seg_fin = r_next;
            end else begin
                n_el_fin  = n_el_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg     <= SEG_IDLE;
            r_elapsed <= '0;
            r_env     <= '0;
        end else if (i_cmd.accept) begin
            r_seg     <= n_seg_acc;
            r_elapsed <= n_el_acc;
        end else if (i_cmd.finish && r_timed) begin
            r_env     <= n_env_new;
            r_seg     <= n_seg_fin;
            r_elapsed <= n_el_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_level <= n_env_new[FRAC_BITS -: LVL_W];
            r_phase <= n_seg_fin;
        end
    end

    assign o_level = r_level;
    assign o_phase = r_phase;

endmodule

// ----- hdl/adsr_envelope_generator.sv -----
// Linear ADSR envelope generator: one gate beat in, one level beat out.
//
// Input channel (i_valid/o_ready, i_gate): one beat per audio sample tick.
// Output channel (o_valid/i_ready, o_level/o_phase): the envelope level
// after that tick in Q1.15, and the segment code (idle, attack, decay,
// sustain, release). Configuration goes through a plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); write only while no beat is in flight.
// Times and levels take effect at the next note start.
//
// The step size is a signed restoring division that retires one quotient
// bit per cycle. Each beat passes through accept, operand setup, the
// division and the level update in that order, and the next beat is taken
// only after the level update.
//
// The result sits in an output register, so a new beat is taken while it
// waits; if the receiver stalls, the next result waits in the datapath and
// the input side closes until the output register frees up.
// Reset puts the envelope idle at level zero and restores the register
// defaults; no clearing pass is needed.
module adsr_envelope_generator #(
    parameter int TICK_BITS = aeg_pkg::TICK_BITS_DEF,
    parameter int FRAC_BITS = aeg_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  aeg_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [aeg_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_gate,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [aeg_pkg::LVL_W-1:0] o_level,
    output logic [2:0]                o_phase
);
    import aeg_pkg::*;

    // Accepted beat to o_valid sampled high
    localparam int LATENCY = FRAC_BITS + 4;

    t_dp_cmd dp_cmd;
    t_seg    dp_phase;

    // Sequencer: handshakes and division step count
    aeg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (dp_cmd)
    );

    // Datapath: registers, segment logic, divider, output register
    aeg_dp #(
        .TICK_BITS (TICK_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .i_gate     (i_gate),
        .o_level    (o_level),
        .o_phase    (dp_phase)
    );

    assign o_phase = dp_phase;

    // o_valid must be high at the LATENCY delay after every accepted beat
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> ##LATENCY o_valid)
        else $error("result missing after accepted beat");

    // Idle is only reached when release lands exactly on zero
    a_idle_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_phase == SEG_IDLE) |-> (o_level == '0))
        else $error("nonzero level while idle");

    // No new beat is taken during a division
    a_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("beat accepted while busy");

endmodule
